// ===== rtl/sd2_pkg.sv =====
// sd2_pkg: shared constants, command struct and saturation helpers for
// the 2D smooth-damp block. No dependencies.
package sd2_pkg;

  localparam int CHANNELS_DEF = 16;
  localparam int FRAC_DEF     = 16;
  localparam int VEL_BITS     = 32;
  // fraction bits of the offset clamp ratio
  localparam int RATIO_BITS   = 30;

  // internal saturation limit, 2^61 LSB
  localparam logic [63:0]        SAT_LIM = 64'h2000_0000_0000_0000;
  localparam logic signed [63:0] SAT_POS = 64'sh2000_0000_0000_0000;
  localparam logic signed [63:0] SAT_NEG = -64'sh2000_0000_0000_0000;

  // multiplier command: start pulse and rounding point select
  typedef struct packed {
    logic start;
    logic ratio_mode;
  } mul_cmd_t;

  function automatic logic signed [63:0] sat61(input logic signed [63:0] a);
    if (a > SAT_POS) return SAT_POS;
    if (a < SAT_NEG) return SAT_NEG;
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] a);
    if (a > 64'sd2147483647) return 32'sh7fff_ffff;
    if (a < -64'sd2147483648) return 32'sh8000_0000;
    return a[31:0];
  endfunction

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a[63] ? 64'(-a) : 64'(a);
  endfunction

endpackage

// ===== rtl/sd2_ram.sv =====
// sd2_ram: generic single-write, single-read RAM with registered read data.
// No dependencies beyond sd2_pkg defaults.
module sd2_ram #(
  parameter int WIDTH = 2 * sd2_pkg::VEL_BITS,
  parameter int DEPTH = sd2_pkg::CHANNELS_DEF,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sd2_mul.sv =====
// sd2_mul: 64x64 unsigned multiplier built from one 32x32 product per cycle,
// with a rounded, saturated fixed-point result. Depends on sd2_pkg.
module sd2_mul #(
  parameter int FRACTION_BITS = sd2_pkg::FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sd2_pkg::mul_cmd_t  cmd_i,
  input  logic [63:0]        a_i,
  input  logic [63:0]        b_i,
  output logic               done_o,
  output logic [127:0]       prod_o,
  output logic [63:0]        rnd_o
);

  localparam logic [127:0] HALF_F = 128'd1 << (FRACTION_BITS - 1);
  localparam logic [127:0] HALF_R = 128'd1 << (sd2_pkg::RATIO_BITS - 1);

  logic         busy_q, fin_q, done_q, ratio_q;
  logic [1:0]   cnt_q;
  logic [63:0]  a_q, b_q, rnd_q;
  logic [127:0] acc_q;
  logic [31:0]  al, bl;
  logic [63:0]  pp;
  logic [6:0]   shamt;
  logic [127:0] pp_sh, rsum, rshift;
  logic [63:0]  rnd_d;

  // pick limbs for this partial product and align it
  always_comb begin
    al     = cnt_q[1] ? a_q[63:32] : a_q[31:0];
    bl     = cnt_q[0] ? b_q[63:32] : b_q[31:0];
    pp     = 64'(al) * 64'(bl);
    shamt  = {2'(cnt_q[1]) + 2'(cnt_q[0]), 5'd0};
    pp_sh  = 128'(pp) << shamt;
    rsum   = acc_q + (ratio_q ? HALF_R : HALF_F);
    rshift = ratio_q ? (rsum >> sd2_pkg::RATIO_BITS) : (rsum >> FRACTION_BITS);
    rnd_d  = (rshift > 128'(sd2_pkg::SAT_LIM)) ? sd2_pkg::SAT_LIM : rshift[63:0];
  end

  // sequence partial products, then round and register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fin_q;
      fin_q  <= 1'b0;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 2'd1;
        if (cnt_q == 2'd3) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
    end
  end

  // operands, accumulator and result
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      a_q     <= a_i;
      b_q     <= b_i;
      ratio_q <= cmd_i.ratio_mode;
      acc_q   <= '0;
    end else if (busy_q) begin
      acc_q <= acc_q + pp_sh;
    end
    if (fin_q) begin
      rnd_q <= rnd_d;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
  assign rnd_o  = rnd_q;

endmodule

// ===== rtl/sd2_div.sv =====
// sd2_div: 64-bit unsigned restoring divider, one quotient bit per cycle.
// No package dependencies.
module sd2_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);

  logic        busy_q, done_q;
  logic [5:0]  cnt_q;
  logic [63:0] num_q, den_q, quo_q;
  logic [64:0] rem_q, rem_sh, rem_nx;
  logic        ge;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q[63:0], num_q[63]};
    ge     = rem_sh >= {1'b0, den_q};
    rem_nx = ge ? rem_sh - {1'b0, den_q} : rem_sh;
  end

  // step count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // shift dividend in, quotient bits out
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[62:0], 1'b0};
      rem_q <= rem_nx;
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== rtl/sd2_sqrt.sv =====
// sd2_sqrt: integer square root of a 64-bit value, two radicand bits per
// cycle. No package dependencies.
module sd2_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] val_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic        busy_q, done_q;
  logic [4:0]  cnt_q;
  logic [63:0] v_q, r_q, bit_q, trial;
  logic        ge;

  always_comb begin
    trial = r_q + bit_q;
    ge    = v_q >= trial;
  end

  // step count and done pulse
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // digit-by-digit root
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= val_i;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (ge) begin
        v_q <= v_q - trial;
        r_q <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[31:0];

endmodule

// ===== rtl/smooth_damp_2d.sv =====
// smooth_damp_2d: one transaction in flight; each item runs two 64-step divisions
// (three when the offset is clamped), a 32-step square root and 20 multiplies
// (22 when clamped) on one shared multiplier; a stalled result holds the next
// item back. After reset, a clearing pass zeroes the velocity RAM; no item is
// taken until it ends. Depends on sd2_pkg, sd2_ram, sd2_mul, sd2_div, sd2_sqrt.
module smooth_damp_2d #(
  parameter int CHANNELS      = sd2_pkg::CHANNELS_DEF,
  parameter int FRACTION_BITS = sd2_pkg::FRAC_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         channel_i,
  input  logic signed [31:0] current_x_i,
  input  logic signed [31:0] current_y_i,
  input  logic signed [31:0] target_x_i,
  input  logic signed [31:0] target_y_i,
  input  logic [30:0]        smooth_time_i,
  input  logic [30:0]        max_speed_i,
  input  logic [30:0]        delta_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] velocity_x_o,
  output logic signed [31:0] velocity_y_o
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ST_MIN_RAW = ((1 << FRACTION_BITS) + 5000) / 10000;
  localparam logic [30:0] ST_MIN = (ST_MIN_RAW == 0) ? 31'd1 : 31'(ST_MIN_RAW);
  localparam logic [63:0] ONE       = 64'd1 << FRACTION_BITS;
  localparam logic [63:0] X_MAX     = 64'd1024 << FRACTION_BITS;
  localparam logic [63:0] OMEGA_NUM = 64'd2 << (2 * FRACTION_BITS);
  localparam logic [63:0] EXP_ONE   = 64'd1 << (2 * FRACTION_BITS);
  localparam logic [63:0] C048      = (64'd48 * ONE + 64'd50) / 64'd100;
  localparam logic [63:0] C0235     = (64'd235 * ONE + 64'd500) / 64'd1000;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_LAUNCH, ST_WAIT, ST_DONE
  } state_e;

  typedef enum logic [4:0] {
    S_OMEGA, S_X, S_X2, S_X3, S_A, S_B, S_EXP, S_MC, S_UX2, S_UY2, S_SQRT,
    S_R, S_SCX, S_SCY, S_T1X, S_TX, S_T1Y, S_TY, S_PX, S_NX, S_PY, S_NY,
    S_OX, S_OY, S_DX, S_DY
  } step_e;

  state_e state_q;
  step_e  pc_q;
  logic [AW-1:0] clr_q, slot_d, slot_q;
  logic          out_valid_q;

  // input item and per-item working registers
  logic signed [31:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q, vx_q, vy_q;
  logic [30:0]  st_q, ms_q, dt_q;
  logic [63:0]  omega_q, x_q, x2_q, x3_q, den_q, expq_q, mc_q, sq_q, len_q, ratio_q;
  logic signed [63:0] cx_q, cy_q, tx_q, ty_q, nx_q, ny_q, ox_q, oy_q;
  logic [127:0] px_q, py_q;
  logic         neg_q;
  logic signed [31:0] out_x_q, out_y_q, vel_x_q, vel_y_q;

  // unit interfaces
  sd2_pkg::mul_cmd_t mul_cmd;
  logic [63:0]  mul_a, mul_b, mul_rnd, div_num, div_den, div_quo, sqrt_val;
  logic [127:0] mul_prod;
  logic [31:0]  sqrt_root;
  logic         mul_done, div_done, sqrt_done, div_start, sqrt_start;
  logic         mul_neg, is_div, is_sqrt, unit_done, load_out;

  // helpers
  logic [4:0]   slot_v;
  logic [63:0]  cx_mag, cy_mag, ux, uy, len_d;
  logic         big, snap;
  logic signed [63:0] osum_x, osum_y, ax, ay, bx, by, sres;
  logic [1:0]   sgx, sgy;
  logic signed [31:0] nx_fin, ny_fin, ox_fin, oy_fin;
  logic         ram_we;
  logic [AW-1:0] ram_waddr;
  logic [63:0]  ram_wdata, ram_rdata;

  // product sign: {positive, negative}, zero when either factor is zero
  function automatic logic [1:0] psign(input logic signed [63:0] a,
                                       input logic signed [63:0] b);
    if (a == 64'sd0 || b == 64'sd0) return 2'b00;
    return (a[63] == b[63]) ? 2'b10 : 2'b01;
  endfunction

  // fold channel number into the velocity slot range
  always_comb begin
    slot_v = {1'b0, channel_i};
    if (CHANNELS < 16) begin
      for (int i = 0; i < 16; i++) begin
        if (slot_v >= 5'(CHANNELS)) slot_v = slot_v - 5'(CHANNELS);
      end
    end
    slot_d = AW'(slot_v);
  end

  // operand selection for the current step
  always_comb begin
    cx_mag  = sd2_pkg::mag64(cx_q);
    cy_mag  = sd2_pkg::mag64(cy_q);
    big     = (|cx_mag[63:31]) | (|cy_mag[63:31]);
    ux      = big ? (cx_mag >> 1) : cx_mag;
    uy      = big ? (cy_mag >> 1) : cy_mag;
    len_d   = big ? {31'd0, sqrt_root, 1'b0} : {32'd0, sqrt_root};
    osum_x  = sd2_pkg::sat61(cx_q + tx_q);
    osum_y  = sd2_pkg::sat61(cy_q + ty_q);
    ax      = 64'(tgt_x_q) - 64'(cur_x_q);
    ay      = 64'(tgt_y_q) - 64'(cur_y_q);
    bx      = ox_q - 64'(tgt_x_q);
    by      = oy_q - 64'(tgt_y_q);
    is_div  = pc_q inside {S_OMEGA, S_EXP, S_R};
    is_sqrt = pc_q == S_SQRT;
    mul_a    = '0;
    mul_b    = '0;
    mul_neg  = 1'b0;
    div_num  = '0;
    div_den  = 64'd1;
    sqrt_val = sq_q;
    case (pc_q)
      S_OMEGA: begin div_num = OMEGA_NUM; div_den = 64'(st_q); end
      S_X:     begin mul_a = omega_q; mul_b = 64'(dt_q); end
      S_X2:    begin mul_a = x_q; mul_b = x_q; end
      S_X3:    begin mul_a = x2_q; mul_b = x_q; end
      S_A:     begin mul_a = C048; mul_b = x2_q; end
      S_B:     begin mul_a = C0235; mul_b = x3_q; end
      S_EXP:   begin div_num = EXP_ONE + (den_q >> 1); div_den = den_q; end
      S_MC:    begin mul_a = 64'(ms_q); mul_b = 64'(st_q); end
      S_UX2:   begin mul_a = ux; mul_b = ux; end
      S_UY2:   begin mul_a = uy; mul_b = uy; end
      S_SQRT:  sqrt_val = sq_q;
      S_R:     begin div_num = mc_q << sd2_pkg::RATIO_BITS; div_den = len_q; end
      S_SCX:   begin mul_a = cx_mag; mul_b = ratio_q; mul_neg = cx_q[63]; end
      S_SCY:   begin mul_a = cy_mag; mul_b = ratio_q; mul_neg = cy_q[63]; end
      S_T1X:   begin mul_a = omega_q; mul_b = cx_mag; mul_neg = cx_q[63]; end
      S_T1Y:   begin mul_a = omega_q; mul_b = cy_mag; mul_neg = cy_q[63]; end
      S_TX: begin
        mul_a = sd2_pkg::mag64(tx_q); mul_b = 64'(dt_q); mul_neg = tx_q[63];
      end
      S_TY: begin
        mul_a = sd2_pkg::mag64(ty_q); mul_b = 64'(dt_q); mul_neg = ty_q[63];
      end
      S_PX: begin
        mul_a = omega_q; mul_b = sd2_pkg::mag64(tx_q); mul_neg = tx_q[63];
      end
      S_PY: begin
        mul_a = omega_q; mul_b = sd2_pkg::mag64(ty_q); mul_neg = ty_q[63];
      end
      S_NX: begin
        mul_a = sd2_pkg::mag64(nx_q); mul_b = expq_q; mul_neg = nx_q[63];
      end
      S_NY: begin
        mul_a = sd2_pkg::mag64(ny_q); mul_b = expq_q; mul_neg = ny_q[63];
      end
      S_OX: begin
        mul_a = sd2_pkg::mag64(osum_x); mul_b = expq_q; mul_neg = osum_x[63];
      end
      S_OY: begin
        mul_a = sd2_pkg::mag64(osum_y); mul_b = expq_q; mul_neg = osum_y[63];
      end
      S_DX:    begin mul_a = sd2_pkg::mag64(ax); mul_b = sd2_pkg::mag64(bx); end
      S_DY:    begin mul_a = sd2_pkg::mag64(ay); mul_b = sd2_pkg::mag64(by); end
      default: mul_a = '0;
    endcase
    mul_cmd.start      = (state_q == ST_LAUNCH) && !is_div && !is_sqrt;
    mul_cmd.ratio_mode = pc_q inside {S_SCX, S_SCY};
    div_start  = (state_q == ST_LAUNCH) && is_div;
    sqrt_start = (state_q == ST_LAUNCH) && is_sqrt;
    unit_done  = is_div ? div_done : (is_sqrt ? sqrt_done : mul_done);
    sres       = neg_q ? -$signed(mul_rnd) : $signed(mul_rnd);
  end

  // overshoot test and final values
  always_comb begin
    sgx = psign(ax, bx);
    sgy = psign(ay, by);
    if (!sgx[0] && !sgy[0]) begin
      snap = sgx[1] | sgy[1];
    end else if (!sgx[1] && !sgy[1]) begin
      snap = 1'b0;
    end else if (sgx[1]) begin
      snap = px_q > py_q;
    end else begin
      snap = py_q > px_q;
    end
    nx_fin   = snap ? 32'sd0 : sd2_pkg::sat32(nx_q);
    ny_fin   = snap ? 32'sd0 : sd2_pkg::sat32(ny_q);
    ox_fin   = snap ? tgt_x_q : sd2_pkg::sat32(ox_q);
    oy_fin   = snap ? tgt_y_q : sd2_pkg::sat32(oy_q);
    load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);
    ram_we    = (state_q == ST_CLEAR) || load_out;
    ram_waddr = (state_q == ST_CLEAR) ? clr_q : slot_q;
    ram_wdata = (state_q == ST_CLEAR) ? 64'd0 : {ny_fin, nx_fin};
  end

  // sequencer state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      pc_q        <= S_OMEGA;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !load_out) out_valid_q <= 1'b0;
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(CHANNELS - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_READ;
        end
        ST_READ: begin
          pc_q    <= S_OMEGA;
          state_q <= ST_LAUNCH;
        end
        ST_LAUNCH: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (unit_done) begin
            if (pc_q == S_DY) begin
              state_q <= ST_DONE;
            end else begin
              state_q <= ST_LAUNCH;
              if (pc_q == S_SQRT) begin
                pc_q <= (len_d > mc_q) ? S_R : S_T1X;
              end else begin
                pc_q <= step_e'(pc_q + 5'd1);
              end
            end
          end
        end
        ST_DONE: begin
          if (load_out) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath: capture, per-step write-back, result
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      slot_q  <= slot_d;
      cur_x_q <= current_x_i;
      cur_y_q <= current_y_i;
      tgt_x_q <= target_x_i;
      tgt_y_q <= target_y_i;
      st_q    <= (smooth_time_i < ST_MIN) ? ST_MIN : smooth_time_i;
      ms_q    <= max_speed_i;
      dt_q    <= delta_time_i;
    end
    if (state_q == ST_READ) begin
      vx_q <= ram_rdata[31:0];
      vy_q <= ram_rdata[63:32];
      cx_q <= 64'(cur_x_q) - 64'(tgt_x_q);
      cy_q <= 64'(cur_y_q) - 64'(tgt_y_q);
    end
    if (state_q == ST_LAUNCH) neg_q <= mul_neg;
    if (state_q == ST_WAIT && unit_done) begin
      case (pc_q)
        S_OMEGA: omega_q <= div_quo;
        S_X:     x_q     <= (mul_rnd > X_MAX) ? X_MAX : mul_rnd;
        S_X2:    x2_q    <= mul_rnd;
        S_X3:    x3_q    <= mul_rnd;
        S_A:     den_q   <= ONE + x_q + mul_rnd;
        S_B:     den_q   <= den_q + mul_rnd;
        S_EXP:   expq_q  <= div_quo;
        S_MC:    mc_q    <= mul_rnd;
        S_UX2:   sq_q    <= mul_prod[63:0];
        S_UY2:   sq_q    <= sq_q + mul_prod[63:0];
        S_SQRT:  len_q   <= len_d;
        S_R:     ratio_q <= div_quo;
        S_SCX:   cx_q    <= sres;
        S_SCY:   cy_q    <= sres;
        S_T1X:   tx_q    <= sd2_pkg::sat61(64'(vx_q) + sres);
        S_TX:    tx_q    <= sres;
        S_T1Y:   ty_q    <= sd2_pkg::sat61(64'(vy_q) + sres);
        S_TY:    ty_q    <= sres;
        S_PX:    nx_q    <= sd2_pkg::sat61(64'(vx_q) - sres);
        S_NX:    nx_q    <= sres;
        S_PY:    ny_q    <= sd2_pkg::sat61(64'(vy_q) - sres);
        S_NY:    ny_q    <= sres;
        S_OX:    ox_q    <= sd2_pkg::sat61(64'(cur_x_q) - cx_q + sres);
        S_OY:    oy_q    <= sd2_pkg::sat61(64'(cur_y_q) - cy_q + sres);
        S_DX:    px_q    <= mul_prod;
        S_DY:    py_q    <= mul_prod;
        default: px_q    <= mul_prod;
      endcase
    end
    if (load_out) begin
      out_x_q <= ox_fin;
      out_y_q <= oy_fin;
      vel_x_q <= nx_fin;
      vel_y_q <= ny_fin;
    end
  end

  sd2_ram #(
    .WIDTH (2 * sd2_pkg::VEL_BITS),
    .DEPTH (CHANNELS)
  ) u_vel_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (slot_d),
    .rdata_o (ram_rdata)
  );

  sd2_mul #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (mul_cmd),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod),
    .rnd_o  (mul_rnd)
  );

  sd2_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  sd2_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .val_i   (sqrt_val),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign in_ready_o   = state_q == ST_IDLE;
  assign out_valid_o  = out_valid_q;
  assign out_x_o      = out_x_q;
  assign out_y_o      = out_y_q;
  assign velocity_x_o = vel_x_q;
  assign velocity_y_o = vel_y_q;

endmodule

// ===== rtl/sd2_checker.sv =====
// sd2_checker: port-level checks for smooth_damp_2d, attached by bind.
// Depends only on the top-level port list.
module sd2_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] out_x_o,
  input logic signed [31:0] out_y_o,
  input logic signed [31:0] velocity_x_o,
  input logic signed [31:0] velocity_y_o
);

  // hold a stalled result transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) &&
      $stable(out_y_o) && $stable(velocity_x_o) && $stable(velocity_y_o))
    else $error("stalled result changed");

  // drop ready after taking an item: one item in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after accept");

  // no result can appear in the cycle after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !$rose(out_valid_o))
    else $error("result appeared too early");

endmodule

bind smooth_damp_2d sd2_checker u_sd2_checker (.*);
